/* src/ssv_pkg.sv */
package ssv_pkg;

   localparam int DUTY_BITS   = 8;
   localparam int VOLUME_BITS = 15;
   localparam int SAMPLE_BITS = 16;
   localparam int INDEX_BITS  = 3;

   localparam logic [DUTY_BITS-1:0] DUTY_RESET = 8'd128;

   localparam logic [INDEX_BITS-1:0] CSR_START_STEP = 3'd0;
   localparam logic [INDEX_BITS-1:0] CSR_END_STEP   = 3'd1;
   localparam logic [INDEX_BITS-1:0] CSR_DUTY       = 3'd2;
   localparam logic [INDEX_BITS-1:0] CSR_VOLUME     = 3'd3;
   localparam logic [INDEX_BITS-1:0] CSR_LENGTH     = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_BUSY   = 3'b010,
      ST_FINISH = 3'b100
   } voice_state_type;

   typedef enum logic [2:0] {
      MD_IDLE = 3'b001,
      MD_MUL  = 3'b010,
      MD_DIV  = 3'b100
   } muldiv_state_type;

endpackage

/* src/ssv_muldiv.sv */
module ssv_muldiv #(
   parameter int AW = 24,
   parameter int BW = 16,
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [AW-1:0] a,
   input  logic [BW-1:0] b,
   input  logic [DW-1:0] d,
   output logic          busy,
   output logic [AW-1:0] quo
);

   localparam int PW = AW + BW;
   localparam int CW = $clog2(PW + 1);

   ssv_pkg::muldiv_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [AW-1:0] a_ff, a_in;
   logic [DW-1:0] d_ff, d_in;
   logic [DW-1:0] rem_ff, rem_in;

   logic [AW:0] sum;
   logic [DW:0] trial;
   logic        ge;

   always_comb begin
      sum   = {1'b0, acc_ff[PW-1:BW]} + (acc_ff[0] ? {1'b0, a_ff} : {(AW+1){1'b0}});
      trial = {rem_ff, acc_ff[PW-1]};
      ge    = trial >= {1'b0, d_ff};

      state_in = state_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;

      case (state_ff)
         ssv_pkg::MD_IDLE: begin
            if (start) begin
               state_in = ssv_pkg::MD_MUL;
               cnt_in   = CW'(BW - 1);
               acc_in   = {{AW{1'b0}}, b};
               a_in     = a;
               d_in     = d;
               rem_in   = '0;
            end
         end
         ssv_pkg::MD_MUL: begin
            acc_in = {sum, acc_ff[BW-1:1]};
            if (cnt_ff == '0) begin
               state_in = ssv_pkg::MD_DIV;
               cnt_in   = CW'(PW - 1);
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ssv_pkg::MD_DIV: begin
            rem_in = ge ? DW'(trial - {1'b0, d_ff}) : trial[DW-1:0];
            acc_in = {acc_ff[PW-2:0], ge};
            if (cnt_ff == '0) begin
               state_in = ssv_pkg::MD_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            state_in = ssv_pkg::MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssv_pkg::MD_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
   end

   assign busy = (state_ff != ssv_pkg::MD_IDLE);
   assign quo  = acc_ff[AW-1:0];

endmodule

/* src/square_sweep_voice.sv */
// Square-wave voice with a linear pitch glide and a linear decay; each request is one sample
// tick and gives one response. A request that plays a clip sample waits on the glide
// unit's bit-serial multiply and restoring divide; the decay unit runs alongside it and
// finishes sooner. A request while the voice is idle skips both units and goes straight
// to the finish state. One request is worked on at a time; a finished response waits in
// the output register while the next request is taken. Write the registers only while idle.
module square_sweep_voice #(
   parameter int PHASE_BITS = 24,
   parameter int COUNT_BITS = 16,
   localparam int CSR_BITS = (PHASE_BITS > COUNT_BITS) ? PHASE_BITS : COUNT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ssv_pkg::INDEX_BITS-1:0]       csr_index,
   input  logic [CSR_BITS-1:0]                  csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [ssv_pkg::SAMPLE_BITS-1:0] rsp_sample,
   output logic                                 rsp_last,
   output logic                                 rsp_active
);

   localparam int VB = ssv_pkg::VOLUME_BITS;
   localparam int SB = ssv_pkg::SAMPLE_BITS;
   localparam int DB = ssv_pkg::DUTY_BITS;

   logic [PHASE_BITS-1:0] start_step_ff, end_step_ff;
   logic [DB-1:0]         duty_ff;
   logic [VB-1:0]         volume_ff;
   logic [COUNT_BITS-1:0] length_ff;

   ssv_pkg::voice_state_type state_ff, state_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [COUNT_BITS-1:0] idx_ff, idx_in;
   logic                  playing_ff, playing_in;
   logic                  go_ff, go_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]         sample_ff, sample_in;
   logic                  last_ff, last_in;
   logic                  active_ff, active_in;

   logic                  accept, rsp_take, rsp_free;
   logic                  play_eff, go_now, down;
   logic [COUNT_BITS-1:0] idx_eff;
   logic [PHASE_BITS-1:0] diff, step, phase_sum;
   logic [PHASE_BITS-1:0] glide_q;
   logic [VB-1:0]         amp;
   logic [SB-1:0]         amp_ext;
   logic [COUNT_BITS:0]   idx_inc;
   logic                  fin;
   logic                  glide_busy, level_busy, md_start;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_step_ff <= '0;
         end_step_ff   <= '0;
         duty_ff       <= ssv_pkg::DUTY_RESET;
         volume_ff     <= '0;
         length_ff     <= COUNT_BITS'(1);
      end else if (csr_we) begin
         case (csr_index)
            ssv_pkg::CSR_START_STEP: start_step_ff <= csr_wdata[PHASE_BITS-1:0];
            ssv_pkg::CSR_END_STEP:   end_step_ff   <= csr_wdata[PHASE_BITS-1:0];
            ssv_pkg::CSR_DUTY:       duty_ff       <= csr_wdata[DB-1:0];
            ssv_pkg::CSR_VOLUME:     volume_ff     <= csr_wdata[VB-1:0];
            ssv_pkg::CSR_LENGTH:     length_ff     <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign accept   = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign down     = end_step_ff < start_step_ff;
   assign diff     = down ? (start_step_ff - end_step_ff) : (end_step_ff - start_step_ff);
   assign play_eff = req_restart ? (length_ff != '0) : playing_ff;
   assign idx_eff  = req_restart ? '0 : idx_ff;
   assign go_now   = play_eff && (idx_eff < length_ff);
   assign md_start = accept && go_now;

   ssv_muldiv #(
      .AW(PHASE_BITS),
      .BW(COUNT_BITS),
      .DW(COUNT_BITS)
   ) u_glide (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .a     (diff),
      .b     (idx_eff),
      .d     (length_ff),
      .busy  (glide_busy),
      .quo   (glide_q)
   );

   ssv_muldiv #(
      .AW(VB),
      .BW(COUNT_BITS),
      .DW(COUNT_BITS)
   ) u_level (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .a     (volume_ff),
      .b     (length_ff - idx_eff),
      .d     (length_ff),
      .busy  (level_busy),
      .quo   (amp)
   );

   assign step      = down ? (start_step_ff - glide_q) : (start_step_ff + glide_q);
   assign phase_sum = phase_ff + step;
   assign amp_ext   = {{(SB-VB){1'b0}}, amp};
   assign idx_inc   = {1'b0, idx_ff} + 1'b1;
   assign fin       = (idx_inc == {1'b0, length_ff});

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      playing_in   = playing_ff;
      go_in        = go_ff;
      rsp_valid_in = rsp_take ? 1'b0 : rsp_valid_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      active_in    = active_ff;

      case (state_ff)
         ssv_pkg::ST_IDLE: begin
            if (accept) begin
               phase_in   = req_restart ? '0 : phase_ff;
               idx_in     = idx_eff;
               playing_in = go_now;
               go_in      = go_now;
               state_in   = go_now ? ssv_pkg::ST_BUSY : ssv_pkg::ST_FINISH;
            end
         end
         ssv_pkg::ST_BUSY: begin
            if (!glide_busy && !level_busy) begin
               state_in = ssv_pkg::ST_FINISH;
            end
         end
         ssv_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ssv_pkg::ST_IDLE;
               if (go_ff) begin
                  phase_in   = phase_sum;
                  idx_in     = idx_inc[COUNT_BITS-1:0];
                  playing_in = !fin;
                  sample_in  = (phase_sum[PHASE_BITS-1 -: DB] < duty_ff) ? amp_ext
                                                                         : SB'(0) - amp_ext;
                  last_in    = fin;
                  active_in  = 1'b1;
               end else begin
                  sample_in = '0;
                  last_in   = 1'b0;
                  active_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ssv_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssv_pkg::ST_IDLE;
         phase_ff     <= '0;
         idx_ff       <= '0;
         playing_ff   <= 1'b0;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         playing_ff   <= playing_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      last_ff   <= last_in;
      active_ff <= active_in;
   end

   assign req_stall  = (state_ff != ssv_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = sample_ff;
   assign rsp_last   = last_ff;
   assign rsp_active = active_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ssv_pkg::ST_IDLE))
      else $error("request accepted but voice stayed idle");

   a_units_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      (glide_busy || level_busy) |-> (state_ff == ssv_pkg::ST_BUSY))
      else $error("arithmetic unit running outside busy state");

   a_last_is_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> rsp_active)
      else $error("last flagged on inactive response");

   a_inactive_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_active) |-> (rsp_sample == '0))
      else $error("inactive response carries nonzero sample");
`endif

endmodule
